// ===== src/mlpfi_pkg.sv =====
// Shared types, codes, constants and the sigmoid table of the perceptron block.
package mlpfi_pkg;

  localparam int DATA_WIDTH      = 16;
  localparam int FRAC_BITS       = 12;
  localparam int SLOTS           = 3;
  localparam int MAX_LAYERS_DEF  = 4;
  localparam int MAX_NEURONS_DEF = 64;
  localparam int TBL_STEPS       = 128;
  localparam int TBL_W           = FRAC_BITS + 2;
  localparam int TBL_SH          = FRAC_BITS - 4;
  localparam longint unsigned EXP_STEP_Q30 = 64'd1008687096;

  localparam logic [1:0] MODE_WEIGHT = 2'd0;
  localparam logic [1:0] MODE_BIAS   = 2'd1;
  localparam logic [1:0] MODE_INPUT  = 2'd2;
  localparam logic [1:0] MODE_RUN    = 2'd3;

  localparam logic [1:0] ACT_TANH = 2'd1;
  localparam logic [1:0] ACT_SIG  = 2'd2;

  localparam logic [2:0] CFG_LAYER_COUNT = 3'd0;
  localparam logic [2:0] CFG_INPUT_SIZE  = 3'd1;
  localparam logic [2:0] CFG_HIDDEN1     = 3'd2;
  localparam logic [2:0] CFG_HIDDEN2     = 3'd3;
  localparam logic [2:0] CFG_HIDDEN3     = 3'd4;
  localparam logic [2:0] CFG_ACT_CODES   = 3'd5;

  typedef struct packed {
    logic [1:0]                   mode;
    logic [1:0]                   layer_sel;
    logic [5:0]                   row_index;
    logic [5:0]                   col_index;
    logic signed [DATA_WIDTH-1:0] data_value;
  } req_t;

  typedef struct packed {
    logic [5:0]                   out_index;
    logic signed [DATA_WIDTH-1:0] out_value;
    logic                         out_last;
  } rsp_t;

  typedef struct packed {
    logic       wr_weight;
    logic       wr_bias;
    logic       wr_input;
    logic       bias_rd;
    logic       acc_init;
    logic       mac_issue;
    logic       round;
    logic       act1;
    logic       act2;
    logic       act_wr;
    logic       out_rd;
    logic       out_ld;
    logic       out_last;
    logic [1:0] act_code;
  } cmd_t;

  typedef struct packed {
    logic mac_busy;
    logic out_free;
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BIAS_RD, ST_BIAS_LD, ST_MAC, ST_DRAIN, ST_RND,
    ST_ACT1, ST_ACT2, ST_ACT3, ST_OUT_RD, ST_OUT_LD
  } state_t;

  typedef logic [TBL_W-1:0] sig_tbl_t [0:TBL_STEPS];

  // Quotient of two elaboration-time constants by restoring long division.
  function automatic longint unsigned const_quot(longint unsigned n, longint unsigned q);
    longint unsigned rem;
    longint unsigned quot;
    rem  = 64'd0;
    quot = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem  = {rem[62:0], n[b]};
      quot = quot << 1;
      if (rem >= q) begin
        rem  = rem - q;
        quot = quot | 64'd1;
      end
    end
    return quot;
  endfunction

  // Sigmoid samples at k/16 built from successive rounded powers of e^(-1/16) in Q30.
  function automatic sig_tbl_t build_sig_tbl();
    sig_tbl_t t;
    longint unsigned e;
    longint unsigned num;
    longint unsigned den;
    e   = 64'd1 << 30;
    num = (64'd1 << FRAC_BITS) << 30;
    for (int k = 0; k <= TBL_STEPS; k++) begin
      den  = (64'd1 << 30) + e;
      t[k] = TBL_W'(const_quot(num + (den >> 1), den));
      e    = (e * EXP_STEP_Q30 + (64'd1 << 29)) >> 30;
    end
    return t;
  endfunction

  localparam sig_tbl_t SIG_TBL = build_sig_tbl();

endpackage

// ===== src/mlp_forward_inference.sv =====
// Top level of the fixed-point multilayer perceptron forward pass.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  mlpfi_pkg::req_t
//   rsp       out        rsp_valid / rsp_stall  mlpfi_pkg::rsp_t
//   cfg       in         cfg_we                 cfg_index, cfg_wdata
//
// A run request computes each neuron of each computed layer by the single multiply-accumulate
// walk over the weight memory, then hands out each result of the last layer in turn.
// Reset restores the register defaults and makes every input value read as zero.
// Requests stall during a run; a held result does not block the next request.
module mlp_forward_inference #(
  parameter int MAX_LAYERS  = mlpfi_pkg::MAX_LAYERS_DEF,
  parameter int MAX_NEURONS = mlpfi_pkg::MAX_NEURONS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [6:0]      cfg_wdata,
  input  logic            req_valid,
  output logic            req_stall,
  input  mlpfi_pkg::req_t req_data,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output mlpfi_pkg::rsp_t rsp_data
);

  localparam int CW = $clog2(MAX_NEURONS + 1);

  mlpfi_pkg::cmd_t    cmd;
  mlpfi_pkg::status_t status;
  logic [1:0]         layer;
  logic [CW-1:0]      nrow, ncol;

  mlpfi_ctrl #(.MAX_LAYERS(MAX_LAYERS), .MAX_NEURONS(MAX_NEURONS), .CW(CW)) u_ctrl (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .cmd(cmd), .status(status), .layer(layer), .nrow(nrow), .ncol(ncol)
  );

  mlpfi_dp #(.MAX_NEURONS(MAX_NEURONS), .CW(CW)) u_dp (
    .clk(clk), .rst(rst), .req_data(req_data), .cmd(cmd), .status(status),
    .layer(layer), .nrow(nrow), .ncol(ncol),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
  );

endmodule

// ===== src/mlpfi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mlpfi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/mlpfi_ctrl.sv =====
// Controller: configuration registers, layer and neuron counters and sequencing.
module mlpfi_ctrl #(
  parameter int MAX_LAYERS  = mlpfi_pkg::MAX_LAYERS_DEF,
  parameter int MAX_NEURONS = mlpfi_pkg::MAX_NEURONS_DEF,
  parameter int CW          = $clog2(MAX_NEURONS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [6:0]         cfg_wdata,
  input  logic               req_valid,
  output logic               req_stall,
  input  mlpfi_pkg::req_t    req_data,
  output mlpfi_pkg::cmd_t    cmd,
  input  mlpfi_pkg::status_t status,
  output logic [1:0]         layer,
  output logic [CW-1:0]      nrow,
  output logic [CW-1:0]      ncol
);

  localparam int LMAX = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;

  mlpfi_pkg::state_t state, state_next;
  logic [2:0]    layer_count;
  logic [6:0]    size_reg [4];
  logic [5:0]    act_codes;
  logic [CW-1:0] sz [4];
  logic [2:0]    nl;
  logic [1:0]    layer_next;
  logic [CW-1:0] nrow_next, ncol_next, ncur, ncur_next, nprev, nprev_next;
  logic          accept, row_last;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (size_reg[k] == 7'd0) begin
        sz[k] = CW'(1);
      end else if (32'(size_reg[k]) > MAX_NEURONS) begin
        sz[k] = CW'(MAX_NEURONS);
      end else begin
        sz[k] = CW'(size_reg[k]);
      end
    end
    if (layer_count < 3'd2) begin
      nl = 3'd2;
    end else if (32'(layer_count) > LMAX) begin
      nl = 3'(LMAX);
    end else begin
      nl = layer_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count <= 3'd2;
      for (int k = 0; k < 4; k++) begin
        size_reg[k] <= 7'd1;
      end
      act_codes <= 6'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mlpfi_pkg::CFG_LAYER_COUNT: layer_count <= cfg_wdata[2:0];
        mlpfi_pkg::CFG_INPUT_SIZE:  size_reg[0] <= cfg_wdata;
        mlpfi_pkg::CFG_HIDDEN1:     size_reg[1] <= cfg_wdata;
        mlpfi_pkg::CFG_HIDDEN2:     size_reg[2] <= cfg_wdata;
        mlpfi_pkg::CFG_HIDDEN3:     size_reg[3] <= cfg_wdata;
        mlpfi_pkg::CFG_ACT_CODES:   act_codes <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlpfi_pkg::ST_IDLE;
      layer <= 2'd1;
      nrow  <= '0;
      ncol  <= '0;
      ncur  <= CW'(1);
      nprev <= CW'(1);
    end else begin
      state <= state_next;
      layer <= layer_next;
      nrow  <= nrow_next;
      ncol  <= ncol_next;
      ncur  <= ncur_next;
      nprev <= nprev_next;
    end
  end

  assign accept   = req_valid && !req_stall;
  assign row_last = (nrow == ncur - CW'(1));

  always_comb begin
    state_next = state;
    layer_next = layer;
    nrow_next  = nrow;
    ncol_next  = ncol;
    ncur_next  = ncur;
    nprev_next = nprev;
    req_stall  = 1'b1;
    cmd        = '0;
    unique case (layer)
      2'd2:    cmd.act_code = act_codes[3:2];
      2'd3:    cmd.act_code = act_codes[5:4];
      default: cmd.act_code = act_codes[1:0];
    endcase
    unique case (state)
      mlpfi_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (accept) begin
          unique case (req_data.mode)
            mlpfi_pkg::MODE_WEIGHT: begin
              cmd.wr_weight = (req_data.layer_sel != 2'd0)
                && (32'(req_data.row_index) < MAX_NEURONS)
                && (32'(req_data.col_index) < MAX_NEURONS);
            end
            mlpfi_pkg::MODE_BIAS: begin
              cmd.wr_bias = (req_data.layer_sel != 2'd0)
                && (32'(req_data.row_index) < MAX_NEURONS)
                && (32'(req_data.col_index) < MAX_NEURONS);
            end
            mlpfi_pkg::MODE_INPUT: begin
              cmd.wr_input = 32'(req_data.col_index) < 32'(sz[0]);
            end
            default: begin
              layer_next = 2'd1;
              nprev_next = sz[0];
              ncur_next  = sz[1];
              nrow_next  = '0;
              state_next = mlpfi_pkg::ST_BIAS_RD;
            end
          endcase
        end
      end
      mlpfi_pkg::ST_BIAS_RD: begin
        cmd.bias_rd = 1'b1;
        state_next  = mlpfi_pkg::ST_BIAS_LD;
      end
      mlpfi_pkg::ST_BIAS_LD: begin
        cmd.acc_init = 1'b1;
        ncol_next    = '0;
        state_next   = mlpfi_pkg::ST_MAC;
      end
      mlpfi_pkg::ST_MAC: begin
        cmd.mac_issue = 1'b1;
        ncol_next     = ncol + CW'(1);
        if (ncol == nprev - CW'(1)) begin
          state_next = mlpfi_pkg::ST_DRAIN;
        end
      end
      mlpfi_pkg::ST_DRAIN: begin
        if (!status.mac_busy) begin
          state_next = mlpfi_pkg::ST_RND;
        end
      end
      mlpfi_pkg::ST_RND: begin
        cmd.round  = 1'b1;
        state_next = mlpfi_pkg::ST_ACT1;
      end
      mlpfi_pkg::ST_ACT1: begin
        cmd.act1   = 1'b1;
        state_next = mlpfi_pkg::ST_ACT2;
      end
      mlpfi_pkg::ST_ACT2: begin
        cmd.act2   = 1'b1;
        state_next = mlpfi_pkg::ST_ACT3;
      end
      mlpfi_pkg::ST_ACT3: begin
        cmd.act_wr = 1'b1;
        nrow_next  = nrow + CW'(1);
        state_next = mlpfi_pkg::ST_BIAS_RD;
        if (row_last) begin
          nrow_next = '0;
          if (3'(layer) + 3'd1 == nl) begin
            state_next = mlpfi_pkg::ST_OUT_RD;
          end else begin
            layer_next = layer + 2'd1;
            nprev_next = ncur;
            ncur_next  = sz[layer + 2'd1];
          end
        end
      end
      mlpfi_pkg::ST_OUT_RD: begin
        cmd.out_rd = 1'b1;
        state_next = mlpfi_pkg::ST_OUT_LD;
      end
      mlpfi_pkg::ST_OUT_LD: begin
        cmd.out_last = row_last;
        if (status.out_free) begin
          cmd.out_ld = 1'b1;
          if (row_last) begin
            state_next = mlpfi_pkg::ST_IDLE;
          end else begin
            nrow_next  = nrow + CW'(1);
            state_next = mlpfi_pkg::ST_OUT_RD;
          end
        end
      end
      default: state_next = mlpfi_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== src/mlpfi_dp.sv =====
// Datapath: weight, bias and layer memories, multiply-accumulate, activation, result register.
module mlpfi_dp #(
  parameter int MAX_NEURONS = mlpfi_pkg::MAX_NEURONS_DEF,
  parameter int CW          = $clog2(MAX_NEURONS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  mlpfi_pkg::req_t    req_data,
  input  mlpfi_pkg::cmd_t    cmd,
  output mlpfi_pkg::status_t status,
  input  logic [1:0]         layer,
  input  logic [CW-1:0]      nrow,
  input  logic [CW-1:0]      ncol,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output mlpfi_pkg::rsp_t    rsp_data
);

  localparam int DW   = mlpfi_pkg::DATA_WIDTH;
  localparam int FB   = mlpfi_pkg::FRAC_BITS;
  localparam int TW   = mlpfi_pkg::TBL_W;
  localparam int SH   = mlpfi_pkg::TBL_SH;
  localparam int MN   = MAX_NEURONS;
  localparam int IW   = (MN > 1) ? $clog2(MN) : 1;
  localparam int AW   = 2 * DW + CW + 1;
  localparam int WD   = mlpfi_pkg::SLOTS * MN * MN;
  localparam int BD   = mlpfi_pkg::SLOTS * MN;
  localparam int AD   = 3 * MN;
  localparam int WA   = $clog2(WD);
  localparam int BA   = $clog2(BD);
  localparam int AA   = $clog2(AD);
  localparam int VW   = DW + 3;
  localparam logic signed [AW-1:0] ACC_HI = AW'((2 ** (DW - 1)) - 1);
  localparam logic signed [AW-1:0] ACC_LO = ~ACC_HI;
  localparam logic signed [VW-1:0] V_HI   = VW'((2 ** (DW - 1)) - 1);
  localparam logic signed [VW-1:0] V_LO   = ~V_HI;
  localparam logic signed [VW-1:0] V_ONE  = VW'(2 ** FB);

  logic [WA-1:0]         w_waddr, w_raddr;
  logic [BA-1:0]         b_waddr, b_raddr;
  logic [AA-1:0]         a_waddr, a_raddr;
  logic [DW-1:0]         w_rdata, b_rdata, a_rdata, a_wdata;
  logic                  a_we, a_re;
  logic [1:0]            src_bank, dst_bank;
  logic [MN-1:0]         in_vld;
  logic                  src_vld, v1, v2;
  logic signed [2*DW-1:0] prod;
  logic signed [AW-1:0]  acc, rnd;
  logic signed [DW-1:0]  x;
  logic signed [DW:0]    xs;
  logic [DW:0]           mag;
  logic [DW+1:0]         arg, idx;
  logic [TW-1:0]         lo, d, sp;
  logic [SH-1:0]         fr;
  logic                  tsat, neg;
  logic [1:0]            code;
  logic [TW+SH-1:0]      interp;
  logic signed [VW-1:0]  v, res;
  logic signed [DW-1:0]  act_val;
  logic [5:0]            out_index;
  logic signed [DW-1:0]  out_value;
  logic                  out_last;

  assign dst_bank = layer[0] ? 2'd1 : 2'd2;
  assign src_bank = (layer == 2'd1) ? 2'd0 : (layer[0] ? 2'd2 : 2'd1);

  assign w_waddr = WA'((32'(req_data.layer_sel) - 1) * MN * MN
                   + 32'(req_data.row_index) * MN + 32'(req_data.col_index));
  assign w_raddr = WA'((32'(layer) - 1) * MN * MN + 32'(nrow) * MN + 32'(ncol));
  assign b_waddr = BA'((32'(req_data.layer_sel) - 1) * MN + 32'(req_data.row_index));
  assign b_raddr = BA'((32'(layer) - 1) * MN + 32'(nrow));

  assign a_we    = cmd.wr_input || cmd.act_wr;
  assign a_waddr = cmd.wr_input ? AA'(req_data.col_index)
                                : AA'(32'(dst_bank) * MN + 32'(nrow));
  assign a_wdata = cmd.wr_input ? req_data.data_value : act_val;
  assign a_re    = cmd.mac_issue || cmd.out_rd;
  assign a_raddr = cmd.mac_issue ? AA'(32'(src_bank) * MN + 32'(ncol))
                                 : AA'(32'(dst_bank) * MN + 32'(nrow));

  mlpfi_ram #(.WIDTH(DW), .DEPTH(WD)) u_weight_ram (
    .clk(clk), .we(cmd.wr_weight), .waddr(w_waddr), .wdata(req_data.data_value),
    .re(cmd.mac_issue), .raddr(w_raddr), .rdata(w_rdata)
  );

  mlpfi_ram #(.WIDTH(DW), .DEPTH(BD)) u_bias_ram (
    .clk(clk), .we(cmd.wr_bias), .waddr(b_waddr), .wdata(req_data.data_value),
    .re(cmd.bias_rd), .raddr(b_raddr), .rdata(b_rdata)
  );

  mlpfi_ram #(.WIDTH(DW), .DEPTH(AD)) u_act_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .re(a_re), .raddr(a_raddr), .rdata(a_rdata)
  );

  // Input entries never written read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= '0;
    end else if (cmd.wr_input) begin
      in_vld[IW'(req_data.col_index)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.mac_issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_issue) begin
      src_vld <= (src_bank != 2'd0) || in_vld[ncol[IW-1:0]];
    end
    prod <= $signed(w_rdata) * (src_vld ? $signed(a_rdata) : $signed(DW'(0)));
    if (cmd.acc_init) begin
      acc <= AW'($signed(b_rdata)) <<< FB;
    end else if (v2) begin
      acc <= acc + AW'(prod);
    end
  end

  assign status.mac_busy = v1 || v2;

  assign rnd    = (acc + AW'(2 ** (FB - 1))) >>> FB;
  assign xs     = (DW + 1)'(x);
  assign mag    = xs[DW] ? (DW + 1)'(-xs) : (DW + 1)'(xs);
  assign arg    = (code == mlpfi_pkg::ACT_TANH) ? {mag, 1'b0} : {1'b0, mag};
  assign idx    = arg >> SH;
  assign interp = (TW + SH)'(d) * (TW + SH)'(fr) + (TW + SH)'(2 ** (SH - 1));

  always_ff @(posedge clk) begin
    if (cmd.round) begin
      if (rnd > ACC_HI) begin
        x <= ACC_HI[DW-1:0];
      end else if (rnd < ACC_LO) begin
        x <= ACC_LO[DW-1:0];
      end else begin
        x <= rnd[DW-1:0];
      end
      code <= cmd.act_code;
    end
    if (cmd.act1) begin
      tsat <= idx >= (DW + 2)'(mlpfi_pkg::TBL_STEPS);
      lo   <= mlpfi_pkg::SIG_TBL[idx[6:0]];
      d    <= mlpfi_pkg::SIG_TBL[8'(idx[6:0]) + 8'd1] - mlpfi_pkg::SIG_TBL[idx[6:0]];
      fr   <= arg[SH-1:0];
      neg  <= x[DW-1];
    end
    if (cmd.act2) begin
      sp <= tsat ? mlpfi_pkg::SIG_TBL[mlpfi_pkg::TBL_STEPS] : lo + TW'(interp >> SH);
    end
  end

  always_comb begin
    case (code)
      mlpfi_pkg::ACT_TANH: begin
        v   = (VW'(sp) <<< 1) - V_ONE;
        res = neg ? -v : v;
      end
      mlpfi_pkg::ACT_SIG: begin
        v   = VW'(sp);
        res = neg ? V_ONE - v : v;
      end
      default: begin
        v   = VW'(x);
        res = v;
      end
    endcase
    if (res > V_HI) begin
      act_val = V_HI[DW-1:0];
    end else if (res < V_LO) begin
      act_val = V_LO[DW-1:0];
    end else begin
      act_val = res[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (cmd.out_ld) begin
      out_index <= 6'(nrow);
      out_value <= $signed(a_rdata);
      out_last  <= cmd.out_last;
    end
  end

  assign status.out_free    = !rsp_valid || !rsp_stall;
  assign rsp_data.out_index = out_index;
  assign rsp_data.out_value = out_value;
  assign rsp_data.out_last  = out_last;

endmodule

// ===== src/mlpfi_checker.sv =====
// Port-level checker of the perceptron block and its binding to the top level.
module mlpfi_port_checks (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_stall,
  input mlpfi_pkg::req_t req_data,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input mlpfi_pkg::rsp_t rsp_data
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(rsp_data))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result present after reset");

  a_run_stalls: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req_data.mode == mlpfi_pkg::MODE_RUN |=> req_stall)
    else $error("request taken during a run");

endmodule

bind mlp_forward_inference mlpfi_port_checks u_chk (.*);
